>>> rtl/fpba_pkg.sv
// Shared codes, sequencer operations and status flags for the block allocator.
package fpba_pkg;

  localparam int ALIGN_BYTES = 32;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_REALLOC = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_ROOM   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_SCAN_INIT, OP_READ_I, OP_READ_IM1, OP_READ_KM1,
    OP_READ_KP1, OP_READ_IR, OP_INC_I, OP_TAKE_K, OP_SAME, OP_CLR_PF,
    OP_TAKE_P, OP_CLR_NF, OP_TAKE_N, OP_FREE_WR, OP_SD_WR, OP_SD_END,
    OP_AL_EVAL, OP_ERR_ROOM, OP_EXACT, OP_SPLIT_INIT, OP_GROW_INIT,
    OP_DEC_I, OP_TAKE_LAST, OP_GROW_SHIFT, OP_SU_WR, OP_INSERT,
    OP_SPLIT_HEAD, OP_REFIND, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       phase1;
    logic       i_lt_cnt;
    logic       used_hit;
    logic       size_eq;
    logic       k_gt0;
    logic       k1_lt_cnt;
    logic       sd_more;
    logic       fit;
    logic       best;
    logic       pick_valid;
    logic       can_split;
    logic       full;
    logic       no_heap;
    logic       i_zero;
    logic       rd_used;
    logic       su_more;
    logic       grow;
    logic       out_free;
  } dp_status_t;

endpackage

>>> rtl/fpba_datapath.sv
// Block table memory, scan and shift registers, and output word register.
module fpba_datapath import fpba_pkg::*; #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  dp_op_t           op,
  input  logic [1:0]       kind,
  input  logic [15:0]      request_size,
  input  logic [15:0]      payload_offset,
  input  logic             cfg_we,
  input  logic             fit_policy,
  input  logic             out_stall,
  output dp_status_t       st,
  output logic             out_valid,
  output logic [15:0]      result_offset,
  output logic [1:0]       status
);

  localparam int HW = $clog2(HEAP_BYTES) + 1;
  localparam int W  = (HW > 17) ? HW : 17;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = $clog2(MAX_BLOCKS);
  localparam logic [W-1:0]  HDR   = W'(HEADER_BYTES);
  localparam logic [W:0]    HEAPL = (W+1)'(HEAP_BYTES);
  localparam logic [CW-1:0] MAXC  = CW'(MAX_BLOCKS);

  typedef struct packed {
    logic [W-1:0] start;
    logic [W-1:0] bytes;
    logic         free;
  } entry_t;

  entry_t mem [MAX_BLOCKS];
  entry_t rd;
  entry_t wdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  logic [1:0]    kind_q;
  logic [15:0]   size_q;
  logic [15:0]   off_q;
  logic [W-1:0]  sa;
  logic          phase1;
  logic [CW-1:0] i;
  logic [CW-1:0] k;
  logic [CW-1:0] lo;
  logic [CW-1:0] count;
  logic [W-1:0]  heap_top;
  logic [W-1:0]  kstart;
  logic [W-1:0]  kbytes;
  logic [W-1:0]  pstart;
  logic [W-1:0]  pbytes;
  logic [W-1:0]  nbytes;
  logic [W-1:0]  ns;
  logic [W-1:0]  add;
  logic          pf;
  logic          nf;
  logic [1:0]    r;
  logic          pick_valid;
  logic          grow;
  logic          policy;
  logic [15:0]   res_off;
  logic [1:0]    res_st;

  logic [16:0]   sz_r;
  logic [W-1:0]  need;
  logic [CW-1:0] m;
  logic [W-1:0]  merged;
  logic [W-1:0]  diff;
  logic          fit;
  logic          out_free;

  always_comb begin
    sz_r = ({1'b0, request_size} + 17'(ALIGN_BYTES - 1)) & ~17'(ALIGN_BYTES - 1);
    need = HDR + sa;
    m = pf ? (k - CW'(1)) : k;
    merged = (pf ? (pbytes + HDR) : '0) + kbytes + (nf ? (HDR + nbytes) : '0);
    diff = kbytes - sa;
    fit = rd.free && (rd.bytes >= sa);
    out_free = !out_valid || !out_stall;
  end

  always_comb begin
    st.kind       = kind_q;
    st.phase1     = phase1;
    st.i_lt_cnt   = i < count;
    st.used_hit   = !rd.free && ((rd.start + HDR) & W'(16'hFFFF)) == W'(off_q);
    st.size_eq    = kbytes == W'(size_q);
    st.k_gt0      = k != '0;
    st.k1_lt_cnt  = ({1'b0, k} + (CW+1)'(1)) < {1'b0, count};
    st.sd_more    = (r != 2'd0) && (({1'b0, i} + (CW+1)'(r)) < {1'b0, count});
    st.fit        = fit;
    st.best       = policy;
    st.pick_valid = pick_valid;
    st.can_split  = diff >= HDR;
    st.full       = count >= MAXC;
    st.no_heap    = ({1'b0, heap_top} + {1'b0, need}) > HEAPL;
    st.i_zero     = i == '0;
    st.rd_used    = !rd.free;
    st.su_more    = i > lo;
    st.grow       = grow;
    st.out_free   = out_free;
  end

  // Table address and write word for the operation of this cycle.
  always_comb begin
    we    = 1'b0;
    waddr = i[AW-1:0];
    wdata = rd;
    raddr = i[AW-1:0];
    unique case (op)
      OP_READ_IM1: raddr = CW'(i - CW'(1)) >> 0 == '0 ? AW'(0) : AW'(i - CW'(1));
      OP_READ_KM1: raddr = AW'(k - CW'(1));
      OP_READ_KP1: raddr = AW'(k + CW'(1));
      OP_READ_IR:  raddr = AW'(i + CW'(r));
      OP_FREE_WR: begin
        we    = 1'b1;
        waddr = m[AW-1:0];
        wdata = '{start: pf ? pstart : kstart, bytes: merged, free: 1'b1};
      end
      OP_SD_WR: begin
        we    = 1'b1;
        waddr = i[AW-1:0];
      end
      OP_SU_WR: begin
        we    = 1'b1;
        waddr = i[AW-1:0];
        wdata = '{start: rd.start + add, bytes: rd.bytes, free: rd.free};
      end
      OP_EXACT: begin
        we    = 1'b1;
        waddr = k[AW-1:0];
        wdata = '{start: kstart, bytes: kbytes, free: 1'b0};
      end
      OP_INSERT: begin
        we = 1'b1;
        if (grow) begin
          waddr = k[AW-1:0];
          wdata = '{start: ns, bytes: sa, free: 1'b0};
        end else begin
          waddr = AW'(k + CW'(1));
          wdata = '{start: kstart + HDR + sa, bytes: diff - HDR, free: 1'b1};
        end
      end
      OP_SPLIT_HEAD: begin
        we    = 1'b1;
        waddr = k[AW-1:0];
        wdata = '{start: kstart, bytes: sa, free: 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      heap_top   <= '0;
      policy     <= 1'b0;
      out_valid  <= 1'b0;
      phase1     <= 1'b0;
      pick_valid <= 1'b0;
      grow       <= 1'b0;
    end else begin
      if (cfg_we) begin
        policy <= fit_policy;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (op)
        OP_LATCH: begin
          kind_q  <= kind;
          size_q  <= request_size;
          off_q   <= payload_offset;
          sa      <= W'(sz_r);
          phase1  <= 1'b0;
          res_off <= '0;
          res_st  <= ST_NOT_FOUND;
        end
        OP_SCAN_INIT: begin
          i          <= '0;
          pick_valid <= 1'b0;
        end
        OP_INC_I: i <= i + CW'(1);
        OP_TAKE_K: begin
          k      <= i;
          kstart <= rd.start;
          kbytes <= rd.bytes;
        end
        OP_SAME: begin
          res_off <= off_q;
          res_st  <= ST_OK;
        end
        OP_CLR_PF: pf <= 1'b0;
        OP_TAKE_P: begin
          pf     <= rd.free;
          pstart <= rd.start;
          pbytes <= rd.bytes;
        end
        OP_CLR_NF: nf <= 1'b0;
        OP_TAKE_N: begin
          nf     <= rd.free;
          nbytes <= rd.bytes;
        end
        OP_FREE_WR: begin
          res_st <= ST_OK;
          i      <= m + CW'(1);
          r      <= {1'b0, pf} + {1'b0, nf};
        end
        OP_SD_WR:  i <= i + CW'(1);
        OP_SD_END: count <= count - CW'(r);
        OP_AL_EVAL: begin
          if (fit && (!policy || !pick_valid || (kbytes > rd.bytes))) begin
            pick_valid <= 1'b1;
            k          <= i;
            kstart     <= rd.start;
            kbytes     <= rd.bytes;
          end
          i <= i + CW'(1);
        end
        OP_ERR_ROOM: begin
          res_st  <= ST_NO_ROOM;
          res_off <= '0;
        end
        OP_EXACT: begin
          res_off <= 16'(kstart + HDR);
          res_st  <= ST_OK;
        end
        OP_SPLIT_INIT: begin
          i    <= count;
          lo   <= k + CW'(1);
          add  <= '0;
          grow <= 1'b0;
        end
        OP_GROW_INIT: begin
          i    <= count;
          k    <= '0;
          ns   <= '0;
          grow <= 1'b1;
        end
        OP_DEC_I: i <= i - CW'(1);
        OP_TAKE_LAST: begin
          k  <= i;
          ns <= rd.start + HDR + rd.bytes;
        end
        OP_GROW_SHIFT: begin
          i   <= count;
          lo  <= k;
          add <= need;
        end
        OP_SU_WR: i <= i - CW'(1);
        OP_INSERT: begin
          count  <= count + CW'(1);
          res_st <= ST_OK;
          if (grow) begin
            heap_top <= heap_top + need;
            res_off  <= 16'(ns + HDR);
          end else begin
            res_off  <= 16'(kstart + HDR);
          end
        end
        OP_REFIND: begin
          i      <= '0;
          phase1 <= 1'b1;
        end
        OP_EMIT: begin
          out_valid     <= 1'b1;
          result_offset <= res_off;
          status        <= res_st;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/fpba_ctrl.sv
// Request sequencer that steps the datapath through scans, shifts and writes.
module fpba_ctrl import fpba_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t st,
  output logic       in_stall,
  output dp_op_t     op
);

  typedef enum logic [23:0] {
    S_IDLE       = 24'h000001,
    S_DISPATCH   = 24'h000002,
    S_FU_RD      = 24'h000004,
    S_FU_EV      = 24'h000008,
    S_FU_HIT     = 24'h000010,
    S_FR_RDP     = 24'h000020,
    S_FR_EVP     = 24'h000040,
    S_FR_RDN     = 24'h000080,
    S_FR_EVN     = 24'h000100,
    S_FR_WR      = 24'h000200,
    S_SD_RD      = 24'h000400,
    S_SD_EV      = 24'h000800,
    S_AL_RD      = 24'h001000,
    S_AL_EV      = 24'h002000,
    S_AL_END     = 24'h004000,
    S_GL_RD      = 24'h008000,
    S_GL_EV      = 24'h010000,
    S_GL_END     = 24'h020000,
    S_SU_RD      = 24'h040000,
    S_SU_EV      = 24'h080000,
    S_SU_END     = 24'h100000,
    S_SPLIT_HEAD = 24'h200000,
    S_AL_DONE    = 24'h400000,
    S_FIN        = 24'h800000
  } state_t;

  state_t state, state_next;

  // No word is taken while reset is held.
  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next = state;
    op = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.kind == KIND_ALLOC) begin
          op = OP_SCAN_INIT;
          state_next = S_AL_RD;
        end else if (st.kind == KIND_FREE || st.kind == KIND_REALLOC) begin
          op = OP_SCAN_INIT;
          state_next = S_FU_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FU_RD: begin
        if (st.i_lt_cnt) begin
          op = OP_READ_I;
          state_next = S_FU_EV;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FU_EV: begin
        if (st.used_hit) begin
          op = OP_TAKE_K;
          state_next = S_FU_HIT;
        end else begin
          op = OP_INC_I;
          state_next = S_FU_RD;
        end
      end
      S_FU_HIT: begin
        if (st.kind == KIND_FREE || st.phase1) begin
          state_next = S_FR_RDP;
        end else if (st.size_eq) begin
          op = OP_SAME;
          state_next = S_FIN;
        end else begin
          op = OP_SCAN_INIT;
          state_next = S_AL_RD;
        end
      end
      S_FR_RDP: begin
        if (st.k_gt0) begin
          op = OP_READ_KM1;
          state_next = S_FR_EVP;
        end else begin
          op = OP_CLR_PF;
          state_next = S_FR_RDN;
        end
      end
      S_FR_EVP: begin
        op = OP_TAKE_P;
        state_next = S_FR_RDN;
      end
      S_FR_RDN: begin
        if (st.k1_lt_cnt) begin
          op = OP_READ_KP1;
          state_next = S_FR_EVN;
        end else begin
          op = OP_CLR_NF;
          state_next = S_FR_WR;
        end
      end
      S_FR_EVN: begin
        op = OP_TAKE_N;
        state_next = S_FR_WR;
      end
      S_FR_WR: begin
        op = OP_FREE_WR;
        state_next = S_SD_RD;
      end
      S_SD_RD: begin
        if (st.sd_more) begin
          op = OP_READ_IR;
          state_next = S_SD_EV;
        end else begin
          op = OP_SD_END;
          state_next = S_FIN;
        end
      end
      S_SD_EV: begin
        op = OP_SD_WR;
        state_next = S_SD_RD;
      end
      S_AL_RD: begin
        if (st.i_lt_cnt) begin
          op = OP_READ_I;
          state_next = S_AL_EV;
        end else begin
          state_next = S_AL_END;
        end
      end
      S_AL_EV: begin
        op = OP_AL_EVAL;
        // First fit stops at the lowest free block that is large enough.
        state_next = (st.fit && !st.best) ? S_AL_END : S_AL_RD;
      end
      S_AL_END: begin
        if (st.pick_valid) begin
          if (!st.can_split) begin
            op = OP_EXACT;
            state_next = S_AL_DONE;
          end else if (st.full) begin
            op = OP_ERR_ROOM;
            state_next = S_FIN;
          end else begin
            op = OP_SPLIT_INIT;
            state_next = S_SU_RD;
          end
        end else if (st.full || st.no_heap) begin
          op = OP_ERR_ROOM;
          state_next = S_FIN;
        end else begin
          op = OP_GROW_INIT;
          state_next = S_GL_RD;
        end
      end
      S_GL_RD: begin
        if (st.i_zero) begin
          state_next = S_GL_END;
        end else begin
          op = OP_READ_IM1;
          state_next = S_GL_EV;
        end
      end
      S_GL_EV: begin
        if (st.rd_used) begin
          op = OP_TAKE_LAST;
          state_next = S_GL_END;
        end else begin
          op = OP_DEC_I;
          state_next = S_GL_RD;
        end
      end
      S_GL_END: begin
        op = OP_GROW_SHIFT;
        state_next = S_SU_RD;
      end
      S_SU_RD: begin
        if (st.su_more) begin
          op = OP_READ_IM1;
          state_next = S_SU_EV;
        end else begin
          state_next = S_SU_END;
        end
      end
      S_SU_EV: begin
        op = OP_SU_WR;
        state_next = S_SU_RD;
      end
      S_SU_END: begin
        op = OP_INSERT;
        state_next = st.grow ? S_AL_DONE : S_SPLIT_HEAD;
      end
      S_SPLIT_HEAD: begin
        op = OP_SPLIT_HEAD;
        state_next = S_AL_DONE;
      end
      S_AL_DONE: begin
        if (st.kind == KIND_REALLOC) begin
          op = OP_REFIND;
          state_next = S_FU_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          op = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/fit_policy_block_allocator.sv
// Heap block allocator top level: request sequencer and block table datapath.
// Requests (kind, request_size, payload_offset) arrive on in_valid/in_stall;
// one word is taken when in_valid is high and in_stall is low. Each request
// gives one result word (result_offset, status) on out_valid/out_stall.
// The fit policy is written on cfg_valid/cfg_ready (always ready); the user
// must write it only while idle; the block itself does not enforce this.
// One request is handled at a time. The table is a memory with one write port
// and one registered read port, so each entry visited takes a read state and
// an evaluate state. The result goes to an output register, so once it is
// loaded the next request is taken while the result still waits. If
// out_stall holds a previous result, the finished request waits until that
// register frees. Synchronous reset empties the table (block count and heap
// top zero) and selects first fit; no memory clearing pass is needed.
module fit_policy_block_allocator import fpba_pkg::*; #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] request_size,
  input  logic [15:0] payload_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] result_offset,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        fit_policy
);

  dp_op_t     op;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  fpba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .in_stall (in_stall),
    .op       (op)
  );

  fpba_datapath #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .kind           (kind),
    .request_size   (request_size),
    .payload_offset (payload_offset),
    .cfg_we         (cfg_valid & cfg_ready),
    .fit_policy     (fit_policy),
    .out_stall      (out_stall),
    .st             (st),
    .out_valid      (out_valid),
    .result_offset  (result_offset),
    .status         (status)
  );

endmodule

>>> sim/fit_policy_block_allocator_tb.sv
// Self-checking testbench for the heap block allocator with a built-in table predictor.
`timescale 1ns / 100ps

module fit_policy_block_allocator_tb import fpba_pkg::*;;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 32;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] size;
    logic [15:0] offset;
  } request_t;

  typedef struct packed {
    logic [15:0] offset;
    logic [1:0]  st;
  } reply_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [15:0] request_size;
  logic [15:0] payload_offset;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] result_offset;
  logic [1:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        fit_policy;

  fit_policy_block_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .request_size(request_size), .payload_offset(payload_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_offset(result_offset), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .fit_policy(fit_policy)
  );

  // Predicted heap table.
  int unsigned tbl_start [MAX_BLOCKS];
  int unsigned tbl_bytes [MAX_BLOCKS];
  bit          tbl_free  [MAX_BLOCKS];
  int unsigned tbl_count;
  int unsigned heap_used;
  bit          smallest_pick;

  request_t pending_requests[$];
  reply_t   expected_replies[$];
  int       errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  function automatic void open_slot(int unsigned k);
    for (int unsigned i = tbl_count; i > k; i--) begin
      tbl_start[i] = tbl_start[i-1];
      tbl_bytes[i] = tbl_bytes[i-1];
      tbl_free[i]  = tbl_free[i-1];
    end
    tbl_count++;
  endfunction

  function automatic void close_slot(int unsigned k);
    for (int unsigned i = k; i + 1 < tbl_count; i++) begin
      tbl_start[i] = tbl_start[i+1];
      tbl_bytes[i] = tbl_bytes[i+1];
      tbl_free[i]  = tbl_free[i+1];
    end
    tbl_count--;
  endfunction

  function automatic int find_used_block(logic [15:0] off);
    for (int i = 0; i < tbl_count; i++)
      if (!tbl_free[i] && 16'(tbl_start[i] + HEADER_BYTES) == off) return i;
    return -1;
  endfunction

  function automatic logic [1:0] carve_block(int unsigned size, output logic [15:0] off);
    int unsigned rounded;
    int unsigned diff;
    int unsigned need;
    int unsigned k;
    int unsigned ns;
    int          pick;
    rounded = (size + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
    pick = -1;
    off = '0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_free[i] && tbl_bytes[i] >= rounded) begin
        if (!smallest_pick) begin
          pick = i;
          break;
        end
        if (pick < 0 || tbl_bytes[pick] > tbl_bytes[i]) pick = i;
      end
    end
    if (pick >= 0) begin
      diff = tbl_bytes[pick] - rounded;
      if (diff != 0 && diff >= HEADER_BYTES) begin
        if (tbl_count >= MAX_BLOCKS) return ST_NO_ROOM;
        open_slot(pick + 1);
        tbl_start[pick+1] = tbl_start[pick] + HEADER_BYTES + rounded;
        tbl_bytes[pick+1] = diff - HEADER_BYTES;
        tbl_free[pick+1]  = 1'b1;
        tbl_bytes[pick]   = rounded;
      end
      tbl_free[pick] = 1'b0;
      off = 16'(tbl_start[pick] + HEADER_BYTES);
      return ST_OK;
    end
    need = HEADER_BYTES + rounded;
    k = 0;
    ns = 0;
    if (tbl_count >= MAX_BLOCKS) return ST_NO_ROOM;
    if (need > HEAP_BYTES || heap_used > HEAP_BYTES - need) return ST_NO_ROOM;
    for (int unsigned i = tbl_count; i > 0; i--) begin
      if (!tbl_free[i-1]) begin
        k = i;
        ns = tbl_start[i-1] + HEADER_BYTES + tbl_bytes[i-1];
        break;
      end
    end
    for (int unsigned i = k; i < tbl_count; i++) tbl_start[i] += need;
    open_slot(k);
    tbl_start[k] = ns;
    tbl_bytes[k] = rounded;
    tbl_free[k]  = 1'b0;
    heap_used += need;
    off = 16'(ns + HEADER_BYTES);
    return ST_OK;
  endfunction

  function automatic void release_block(int unsigned k);
    bit pf;
    bit nf;
    tbl_free[k] = 1'b1;
    pf = (k > 0) && tbl_free[k-1];
    nf = (k + 1 < tbl_count) && tbl_free[k+1];
    if (nf) begin
      tbl_bytes[k] += HEADER_BYTES + tbl_bytes[k+1];
      close_slot(k + 1);
    end
    if (pf) begin
      tbl_bytes[k-1] += HEADER_BYTES + tbl_bytes[k];
      close_slot(k);
    end
  endfunction

  function automatic reply_t predict_reply(request_t rq);
    reply_t r;
    int     k;
    r.offset = '0;
    r.st = ST_NOT_FOUND;
    if (rq.kind == KIND_ALLOC) begin
      r.st = carve_block(rq.size, r.offset);
    end else if (rq.kind == KIND_FREE) begin
      k = find_used_block(rq.offset);
      if (k >= 0) begin
        release_block(k);
        r.st = ST_OK;
      end
    end else if (rq.kind == KIND_REALLOC) begin
      k = find_used_block(rq.offset);
      if (k >= 0) begin
        if (tbl_bytes[k] == rq.size) begin
          r.offset = rq.offset;
          r.st = ST_OK;
        end else begin
          r.st = carve_block(rq.size, r.offset);
          if (r.st == ST_OK) begin
            k = find_used_block(rq.offset);
            if (k >= 0) release_block(k);
          end
        end
      end
    end
    if (r.st != ST_OK) r.offset = '0;
    return r;
  endfunction

  task automatic queue_request(logic [1:0] k, logic [15:0] size, logic [15:0] off);
    request_t rq;
    rq = '{kind: k, size: size, offset: off};
    pending_requests.push_back(rq);
    expected_replies.push_back(predict_reply(rq));
  endtask

  // Payload offset of a randomly chosen used block, or a random offset if none.
  function automatic logic [15:0] some_used_offset();
    int used_idx[$];
    for (int i = 0; i < tbl_count; i++) if (!tbl_free[i]) used_idx.push_back(i);
    if (used_idx.size() == 0) return 16'($urandom);
    return 16'(tbl_start[used_idx[$urandom_range(0, used_idx.size() - 1)]] + HEADER_BYTES);
  endfunction

  function automatic int used_bytes_at(logic [15:0] off);
    int k;
    k = find_used_block(off);
    return (k >= 0) ? tbl_bytes[k] : 0;
  endfunction

  function automatic logic [15:0] random_size();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return 16'($urandom);
    if (pick < 20) return 16'($urandom_range(0, 8) * 32);
    return 16'($urandom_range(0, 300));
  endfunction

  task automatic wait_idle();
    while (pending_requests.size() != 0 || expected_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_policy(logic v);
    @(negedge clk);
    cfg_valid  <= 1'b1;
    fit_policy <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    smallest_pick = v;
  endtask

  task automatic random_phase(int count, int alloc_pct);
    logic [15:0] off;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        queue_request(KIND_ALLOC, random_size(), 16'($urandom));
      end else if (pick < 88) begin
        queue_request(KIND_FREE, 16'($urandom), some_used_offset());
      end else if (pick < 95) begin
        off = some_used_offset();
        if ($urandom_range(0, 2) == 0)
          queue_request(KIND_REALLOC, 16'(used_bytes_at(off)), off);
        else
          queue_request(KIND_REALLOC, random_size(), off);
      end else begin
        queue_request(2'($urandom_range(1, 3)), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  // Stimulus and configuration.
  initial begin
    logic [15:0] a;
    logic [15:0] b;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = '0;
    request_size = '0;
    payload_offset = '0;
    cfg_valid = 1'b0;
    fit_policy = 1'b0;
    errors = 0;
    tbl_count = 0;
    heap_used = 0;
    smallest_pick = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_policy(1'b0);
    queue_request(KIND_ALLOC, 16'd0, 16'd0);
    queue_request(KIND_ALLOC, 16'd1, 16'd0);
    queue_request(KIND_ALLOC, 16'd32, 16'd0);
    queue_request(KIND_ALLOC, 16'd33, 16'd0);
    queue_request(KIND_ALLOC, 16'd200, 16'd0);
    queue_request(KIND_ALLOC, 16'hFFFF, 16'hFFFF);
    a = 16'(tbl_start[1] + HEADER_BYTES);
    b = 16'(tbl_start[3] + HEADER_BYTES);
    queue_request(KIND_FREE, 16'd0, a);
    queue_request(KIND_FREE, 16'd0, a);
    queue_request(KIND_REALLOC, 16'd64, b);
    queue_request(KIND_REALLOC, 16'd100, b);
    queue_request(KIND_ALLOC, 16'd10, 16'd0);
    queue_request(KIND_ALLOC, 16'd40, 16'd0);
    queue_request(2'd3, 16'hFFFF, 16'hFFFF);
    queue_request(KIND_REALLOC, 16'd5, 16'h7FFF);
    // Empty the table, then allocate from an all-free table.
    while (some_used_offset() != 16'hFFFF && find_used_block(some_used_offset()) >= 0)
      queue_request(KIND_FREE, 16'd0, some_used_offset());
    queue_request(KIND_ALLOC, 16'd64, 16'd0);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_policy(ph[0] ? 1'b0 : 1'b1);
      random_phase(220, (ph % 3 == 2) ? 35 : 60);
      wait_idle();
    end
    write_policy(1'b1);
    wait_idle();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Request driver.
  logic in_taken;
  logic out_taken;
  int   in_gap;
  int   out_hold;
  bit   in_bursty;
  bit   out_bursty;

  always @(posedge clk) begin
    in_taken  <= in_valid && !in_stall;
    out_taken <= out_valid && !out_stall;
  end

  always @(negedge clk) begin
    request_t rq;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
      in_bursty = 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        rq = pending_requests.pop_front();
        kind           <= rq.kind;
        request_size   <= rq.size;
        payload_offset <= rq.offset;
        in_valid       <= 1'b1;
        if ($urandom_range(0, 39) == 0) in_bursty = !in_bursty;
        in_gap = in_bursty ? 0 : $urandom_range(0, 10);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall pattern: a new hold is drawn after each taken word.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_hold = 0;
      out_bursty = 1'b0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) out_bursty = !out_bursty;
        out_hold = out_bursty ? 0 : $urandom_range(0, 10);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result word: result_offset %0d status %0d", result_offset, status);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (result_offset !== want.offset) begin
          $error("result_offset expected %0d actual %0d", want.offset, result_offset);
          errors++;
        end
        if (status !== want.st) begin
          $error("status expected %0d actual %0d", want.st, status);
          errors++;
        end
      end
    end
  end

endmodule

>>> filelist.f
rtl/fpba_pkg.sv
rtl/fpba_datapath.sv
rtl/fpba_ctrl.sv
rtl/fit_policy_block_allocator.sv
sim/fit_policy_block_allocator_tb.sv
